// ----- src/drss_pkg.sv -----
// shared constants, types and helper functions for the distinct random slot sampler
// no dependencies
package drss_pkg;

    localparam int unsigned SLOT_W     = 11;   // raw slot count / internal slot width
    localparam int unsigned SLOT_OUT_W = 10;
    localparam int unsigned OFF_W      = 51;
    localparam int unsigned SEED_W     = 64;
    localparam int unsigned STRIDE_W   = 41;
    localparam int unsigned BN_W       = 6;
    localparam int unsigned TRY_W      = 10;
    localparam int unsigned CFG_IDX_W  = 1;
    localparam int unsigned CFG_DATA_W = 64;
    localparam int unsigned S_TDATA_W  = 48;
    localparam int unsigned M_TDATA_W  = 72;

    localparam logic [63:0] XS_MULT    = 64'd2685821657736338717;
    localparam logic [31:0] ROUND_MULT = 32'd1000003;
    localparam logic [31:0] FILE_MULT  = 32'd1000033;
    localparam logic [TRY_W-1:0] RETRY_LAST = TRY_W'(999);

    localparam logic [CFG_IDX_W-1:0] REG_SEED   = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_STRIDE = 1'b1;

    localparam logic [STRIDE_W-1:0] STRIDE_RESET = STRIDE_W'(16384);

    function automatic logic [63:0] xorshift(input logic [63:0] x);
        logic [63:0] y;
        y = x ^ (x >> 12);
        y = y ^ (y << 25);
        y = y ^ (y >> 27);
        return y;
    endfunction

endpackage

// ----- src/drss_mul.sv -----
// shared 32x32 multiplier with registered product
// depends on nothing
module drss_mul (
    input  logic        i_clk,
    input  logic [31:0] i_a,
    input  logic [31:0] i_b,
    output logic [63:0] o_p
);
    logic [63:0] r_p;

    always_ff @(posedge i_clk) begin
        r_p <= 64'(i_a) * 64'(i_b);
    end

    assign o_p = r_p;
endmodule

// ----- src/drss_bitmap.sv -----
// seen bitmap storage: one write or read per cycle, registered read data
// depends on nothing
module drss_bitmap #(
    parameter int unsigned DEPTH = 4096,
    parameter int unsigned AW    = 12
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_addr,
    input  logic [63:0]   i_wdata,
    output logic [63:0]   o_rdata
);
    logic [63:0] mem [DEPTH];
    logic [63:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_addr] <= i_wdata;
        end
        r_rdata <= mem[i_addr];
    end

    assign o_rdata = r_rdata;
endmodule

// ----- src/distinct_random_slot_sampler_top.sv -----
// Distinct random slot sampler.
// Input stream: one beat is a batch request {slot_count, batch_count, file_index,
// round_index}. Output stream: one beat per drawn slot in draw order, or a single
// failure beat (tuser high) for zero slot_count or after 1000 duplicate draws.
// Config port: write seed (index 0) or stride (index 1) while the block is idle.
// Reset: after i_rst_n releases, the seen bitmap is cleared one word a cycle,
// all MAX_FILES * ceil(MAX_SLOTS/64) words (4096 by default), with o_s_tready low.
// Timing: one batch at a time. Setup mixes round and file index on the shared 32x32
// multiplier; each draw runs xorshift, the 64-bit product on that multiplier, 8-bit
// remainder steps and a duplicate compare; each emitted slot does a bitmap
// read-modify-write and two multiplier passes for slot * stride.
// A stalled receiver holds the output register; the sequencer waits on it and the
// input stays closed until the batch's last beat has been registered.
// o_m_tdata fields from bit 0: slot[9:0], byte_offset[60:10], novel[61],
// batch_novel[67:62], zero pad. o_m_tuser: status. o_m_tlast: last.
module distinct_random_slot_sampler_top
    import drss_pkg::*;
#(
    parameter int unsigned MAX_FILES = 256,
    parameter int unsigned MAX_BATCH = 32,
    parameter int unsigned MAX_SLOTS = 1024
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_s_tvalid,
    output logic                  o_s_tready,
    // round_index[15:0], file_index[23:16], batch_count[29:24], slot_count[40:30]
    input  logic [S_TDATA_W-1:0]  i_s_tdata,
    output logic                  o_m_tvalid,
    input  logic                  i_m_tready,
    // slot[9:0], byte_offset[60:10], novel[61], batch_novel[67:62]
    output logic [M_TDATA_W-1:0]  o_m_tdata,
    // status[0]
    output logic                  o_m_tuser,
    output logic                  o_m_tlast
);
    localparam int unsigned WPF   = (MAX_SLOTS + 63) / 64;
    localparam int unsigned DEPTH = MAX_FILES * WPF;
    localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW    = $clog2(MAX_BATCH + 1);
    localparam int unsigned IW    = (MAX_BATCH > 1) ? $clog2(MAX_BATCH) : 1;
    localparam int unsigned FMW   = $clog2(MAX_FILES + 1) + 1;

    typedef enum logic [4:0] {
        S_CLR, S_IDLE, S_MIX0, S_MIX1, S_MIX2, S_XS, S_M0, S_M1, S_M2, S_M3,
        S_MOD, S_DUP0, S_DUP1, S_RD, S_WR, S_OUT, S_FAIL
    } t_state;

    t_state r_state;
    logic [SEED_W-1:0]   r_seed;
    logic [STRIDE_W-1:0] r_stride;
    logic [15:0]         r_rnd;
    logic [7:0]          r_file;
    logic [CW-1:0]       r_cnt, r_nu, r_k;
    logic [SLOT_W-1:0]   r_slots, r_rem;
    logic [AW-1:0]       r_base, r_clr;
    logic [63:0]         r_st, r_acc;
    logic [2:0]          r_mcnt;
    logic [TRY_W-1:0]    r_tries;
    logic [MAX_BATCH-1:0] r_match;
    logic [SLOT_W-1:0]   r_used [MAX_BATCH];
    logic                r_nv;
    logic [BN_W-1:0]     r_nov;
    logic                r_ovalid, r_olast, r_ostat, r_onv;
    logic [SLOT_OUT_W-1:0] r_oslot;
    logic [OFF_W-1:0]    r_ooff;
    logic [BN_W-1:0]     r_obn;

    logic [31:0] mul_a, mul_b;
    logic [63:0] prod;
    logic        bm_we;
    logic [AW-1:0] bm_addr;
    logic [63:0] bm_wdata, bm_rdata;

    logic [15:0]       in_rnd;
    logic [7:0]        in_file;
    logic [5:0]        in_cnt;
    logic [SLOT_W-1:0] in_slots, in_slots_sat;
    logic [CW-1:0]     in_cnt_sat;
    logic [FMW-1:0]    fmod;
    logic [SLOT_W-1:0] rem_next;
    logic [SLOT_W-1:0] slot_k;
    logic [63:0]       bit_mask;
    logic              out_free, accept, out_load;
    logic [63:0]       off_full;

    assign in_rnd   = i_s_tdata[15:0];
    assign in_file  = i_s_tdata[23:16];
    assign in_cnt   = i_s_tdata[29:24];
    assign in_slots = i_s_tdata[40:30];
    assign in_slots_sat = (32'(in_slots) > 32'(MAX_SLOTS)) ? SLOT_W'(MAX_SLOTS) : in_slots;
    assign in_cnt_sat   = (32'(in_cnt) > 32'(MAX_BATCH)) ? CW'(MAX_BATCH) : CW'(in_cnt);

    assign o_s_tready = (r_state == S_IDLE);
    assign accept     = i_s_tvalid && o_s_tready;
    assign out_free   = !r_ovalid || i_m_tready;
    assign out_load   = ((r_state == S_OUT) || (r_state == S_FAIL)) && out_free;

    // file index reduced to a bitmap region, restoring remainder by a constant
    always_comb begin
        logic [FMW-1:0] t;
        t = '0;
        for (int i = 7; i >= 0; i--) begin
            t = {t[FMW-2:0], in_file[i]};
            if (t >= FMW'(MAX_FILES)) begin
                t = t - FMW'(MAX_FILES);
            end
        end
        fmod = t;
    end

    // eight remainder steps on the top byte of the product
    always_comb begin
        logic [SLOT_W:0] t;
        logic [SLOT_W-1:0] r;
        r = r_rem;
        for (int i = 0; i < 8; i++) begin
            t = {r, r_acc[63-i]};
            if (t >= {1'b0, r_slots}) begin
                t = t - {1'b0, r_slots};
            end
            r = t[SLOT_W-1:0];
        end
        rem_next = r;
    end

    assign slot_k   = r_used[r_k[IW-1:0]];
    assign bit_mask = 64'(1) << slot_k[5:0];
    assign off_full = r_acc + {prod[31:0], 32'b0};

    // multiplier operand select; the high stride pass is held while the output waits
    always_comb begin
        unique case (r_state)
            S_MIX0:  begin mul_a = 32'(r_rnd);  mul_b = ROUND_MULT; end
            S_MIX1:  begin mul_a = 32'(r_file); mul_b = FILE_MULT;  end
            S_M0:    begin mul_a = r_st[31:0];  mul_b = XS_MULT[31:0];  end
            S_M1:    begin mul_a = r_st[31:0];  mul_b = XS_MULT[63:32]; end
            S_M2:    begin mul_a = r_st[63:32]; mul_b = XS_MULT[31:0];  end
            S_RD:    begin mul_a = 32'(slot_k); mul_b = r_stride[31:0]; end
            S_WR, S_OUT: begin
                mul_a = 32'(slot_k);
                mul_b = 32'(r_stride[STRIDE_W-1:32]);
            end
            default: begin mul_a = '0; mul_b = '0; end
        endcase
    end

    always_comb begin
        bm_we    = (r_state == S_CLR) || (r_state == S_WR);
        bm_addr  = (r_state == S_CLR) ? r_clr : r_base + AW'(slot_k >> 6);
        bm_wdata = (r_state == S_CLR) ? 64'b0 : (bm_rdata | bit_mask);
    end

    drss_mul u_mul (
        .i_clk (i_clk),
        .i_a   (mul_a),
        .i_b   (mul_b),
        .o_p   (prod)
    );

    drss_bitmap #(.DEPTH(DEPTH), .AW(AW)) u_bitmap (
        .i_clk   (i_clk),
        .i_we    (bm_we),
        .i_addr  (bm_addr),
        .i_wdata (bm_wdata),
        .o_rdata (bm_rdata)
    );

    // batch-local draw list, written at the fill count
    always_ff @(posedge i_clk) begin
        if (r_state == S_DUP1 && r_match == '0) begin
            r_used[r_nu[IW-1:0]] <= r_rem;
        end
        for (int i = 0; i < MAX_BATCH; i++) begin
            r_match[i] <= (CW'(i) < r_nu) && (r_used[i] == r_rem);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLR;
            r_clr    <= '0;
            r_seed   <= '0;
            r_stride <= STRIDE_RESET;
            r_ovalid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    REG_SEED:   r_seed   <= i_cfg_data;
                    REG_STRIDE: r_stride <= i_cfg_data[STRIDE_W-1:0];
                    default:    ;
                endcase
            end
            if (r_ovalid && i_m_tready && !out_load) begin
                r_ovalid <= 1'b0;
            end
            unique case (r_state)
                S_CLR: begin
                    r_clr <= r_clr + AW'(1);
                    if (r_clr == AW'(DEPTH - 1)) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (accept) begin
                        r_rnd   <= in_rnd;
                        r_file  <= in_file;
                        r_cnt   <= in_cnt_sat;
                        r_slots <= in_slots_sat;
                        r_base  <= AW'(fmod * WPF);
                        r_nu    <= '0;
                        r_tries <= '0;
                        if (in_cnt == '0) begin
                            r_state <= S_IDLE;
                        end else if (in_slots_sat == '0) begin
                            r_state <= S_FAIL;
                        end else begin
                            r_state <= S_MIX0;
                        end
                    end
                end
                S_MIX0: r_state <= S_MIX1;
                S_MIX1: begin
                    r_st    <= r_seed + prod;
                    r_state <= S_MIX2;
                end
                S_MIX2: begin
                    r_st    <= r_st + prod;
                    r_state <= S_XS;
                end
                S_XS: begin
                    r_st    <= xorshift(r_st);
                    r_state <= S_M0;
                end
                S_M0: r_state <= S_M1;
                S_M1: begin
                    r_acc   <= prod;
                    r_state <= S_M2;
                end
                S_M2: begin
                    r_acc[63:32] <= r_acc[63:32] + prod[31:0];
                    r_state      <= S_M3;
                end
                S_M3: begin
                    r_acc[63:32] <= r_acc[63:32] + prod[31:0];
                    r_rem        <= '0;
                    r_mcnt       <= '0;
                    r_state      <= S_MOD;
                end
                S_MOD: begin
                    r_rem  <= rem_next;
                    r_acc  <= r_acc << 8;
                    r_mcnt <= r_mcnt + 3'd1;
                    if (r_mcnt == 3'd7) begin
                        r_state <= S_DUP0;
                    end
                end
                S_DUP0: r_state <= S_DUP1;
                S_DUP1: begin
                    if (r_match != '0) begin
                        r_tries <= r_tries + TRY_W'(1);
                        r_state <= (r_tries == RETRY_LAST) ? S_FAIL : S_XS;
                    end else begin
                        r_nu <= r_nu + CW'(1);
                        if (r_nu + CW'(1) == r_cnt) begin
                            r_k     <= '0;
                            r_nov   <= '0;
                            r_state <= S_RD;
                        end else begin
                            r_state <= S_XS;
                        end
                    end
                end
                S_RD: r_state <= S_WR;
                S_WR: begin
                    r_acc   <= prod;
                    r_nv    <= !bm_rdata[slot_k[5:0]];
                    r_nov   <= r_nov + BN_W'(!bm_rdata[slot_k[5:0]]);
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    if (out_free) begin
                        r_ovalid <= 1'b1;
                        r_oslot  <= slot_k[SLOT_OUT_W-1:0];
                        r_ooff   <= off_full[OFF_W-1:0];
                        r_onv    <= r_nv;
                        r_ostat  <= 1'b0;
                        r_olast  <= (r_k + CW'(1) == r_nu);
                        r_obn    <= (r_k + CW'(1) == r_nu) ? r_nov : '0;
                        r_k      <= r_k + CW'(1);
                        r_state  <= (r_k + CW'(1) == r_nu) ? S_IDLE : S_RD;
                    end
                end
                S_FAIL: begin
                    if (out_free) begin
                        r_ovalid <= 1'b1;
                        r_oslot  <= '0;
                        r_ooff   <= '0;
                        r_onv    <= 1'b0;
                        r_ostat  <= 1'b1;
                        r_olast  <= 1'b1;
                        r_obn    <= '0;
                        r_state  <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_m_tvalid = r_ovalid;
    assign o_m_tdata  = {4'b0, r_obn, r_onv, r_ooff, r_oslot};
    assign o_m_tuser  = r_ostat;
    assign o_m_tlast  = r_olast;
endmodule

// ----- src/drss_checker.sv -----
// port-level checks for the distinct random slot sampler, bound to the top level
// depends on drss_pkg
module drss_checker
    import drss_pkg::*;
(
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 o_m_tvalid,
    input logic [M_TDATA_W-1:0] o_m_tdata,
    input logic                 o_m_tuser,
    input logic                 o_m_tlast
);
    // a failure beat is always the only, and so the last, beat of its batch
    a_fail_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tuser |-> o_m_tlast)
        else $error("failure beat without last");

    // failure beats carry no slot, offset, novel flag or count
    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tuser |-> o_m_tdata == '0)
        else $error("failure beat with payload");

    // batch novel count only shows on the last beat
    a_bn_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !o_m_tlast |-> o_m_tdata[67:62] == '0)
        else $error("batch novel count before last beat");

    a_rst_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("output valid after reset");
endmodule

bind distinct_random_slot_sampler_top drss_checker u_drss_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .o_m_tvalid (o_m_tvalid),
    .o_m_tdata  (o_m_tdata),
    .o_m_tuser  (o_m_tuser),
    .o_m_tlast  (o_m_tlast)
);

// ----- sim/distinct_random_slot_sampler_top_tb.sv -----
// testbench for distinct_random_slot_sampler_top: batch requests in, drawn slots out
// predicts each batch with its own xorshift64* sampler and seen bitmap; needs drss_pkg
`timescale 1ns / 1ps

class slot_draw_board;
    typedef struct {
        logic [9:0]  slot;
        logic [50:0] byte_offset;
        logic        novel;
        logic        status;
        logic [5:0]  batch_novel;
        logic        last;
    } draw_t;

    draw_t       pending[$];
    logic [63:0] seed;
    logic [40:0] stride;
    bit          seen[256][1024];
    int          errors;

    function new();
        seed   = 64'd0;
        stride = 41'd16384;
        errors = 0;
        foreach (seen[f, s]) seen[f][s] = 1'b0;
    endfunction

    function void set_reg(logic idx, logic [63:0] val);
        if (idx == drss_pkg::REG_SEED) seed = val;
        else stride = val[40:0];
    endfunction

    function void push_fail();
        draw_t d;
        d = '{slot: '0, byte_offset: '0, novel: 1'b0, status: 1'b1,
              batch_novel: '0, last: 1'b1};
        pending.push_back(d);
    endfunction

    // accepted batch request
    function void note_batch(logic [15:0] rnd, logic [7:0] file, logic [5:0] cnt_in,
                             logic [10:0] slots_in);
        int unsigned cnt, slots, nu, tries, nov, k;
        logic [63:0] st, x, r;
        int unsigned used[$];
        int unsigned s;
        bit dup;
        draw_t d;
        cnt = cnt_in;
        slots = slots_in;
        nu = 0; tries = 0; nov = 0;
        if (cnt == 0) return;
        if (cnt > 32) cnt = 32;
        if (slots > 1024) slots = 1024;
        if (slots == 0) begin
            push_fail();
            return;
        end
        st = seed + 64'(rnd) * 64'd1000003 + 64'(file) * 64'd1000033;
        while (nu < cnt && tries < 1000) begin
            x = st;
            x = x ^ (x >> 12);
            x = x ^ (x << 25);
            x = x ^ (x >> 27);
            st = x;
            r = x * 64'd2685821657736338717;
            s = int'(r % 64'(slots));
            dup = 1'b0;
            foreach (used[i]) if (used[i] == s) dup = 1'b1;
            if (dup) tries++;
            else begin
                used.push_back(s);
                nu++;
            end
        end
        if (nu < cnt) begin
            push_fail();
            return;
        end
        for (k = 0; k < nu; k++) begin
            d.slot = used[k][9:0];
            d.byte_offset = 51'(64'(used[k]) * 64'(stride));
            d.novel = !seen[file][used[k]];
            if (d.novel) nov++;
            seen[file][used[k]] = 1'b1;
            d.status = 1'b0;
            d.last = (k + 1 == nu);
            d.batch_novel = d.last ? nov[5:0] : 6'd0;
            pending.push_back(d);
        end
    endfunction

    function void check_beat(logic [71:0] data, logic user, logic lst);
        draw_t e;
        if (pending.size() == 0) begin
            $error("unexpected beat: data %h status %0d last %0d", data, user, lst);
            errors++;
            return;
        end
        e = pending.pop_front();
        if (data[9:0] !== e.slot) begin
            $error("slot: expected %0d actual %0d", e.slot, data[9:0]); errors++;
        end
        if (data[60:10] !== e.byte_offset) begin
            $error("byte_offset: expected %0d actual %0d", e.byte_offset, data[60:10]);
            errors++;
        end
        if (data[61] !== e.novel) begin
            $error("novel: expected %0d actual %0d", e.novel, data[61]); errors++;
        end
        if (user !== e.status) begin
            $error("status: expected %0d actual %0d", e.status, user); errors++;
        end
        if (data[67:62] !== e.batch_novel) begin
            $error("batch_novel: expected %0d actual %0d", e.batch_novel, data[67:62]);
            errors++;
        end
        if (lst !== e.last) begin
            $error("last: expected %0d actual %0d", e.last, lst); errors++;
        end
    endfunction
endclass

module distinct_random_slot_sampler_top_tb;
    import drss_pkg::*;

    localparam int unsigned CYCLE_LIMIT = 40_000_000;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;
    logic                  i_s_tvalid;
    logic                  o_s_tready;
    logic [S_TDATA_W-1:0]  i_s_tdata;    // round, file, count, slot_count
    logic                  o_m_tvalid;
    logic                  i_m_tready;
    logic [M_TDATA_W-1:0]  o_m_tdata;    // slot, offset, novel, batch_novel
    logic                  o_m_tuser;    // status
    logic                  o_m_tlast;

    slot_draw_board board;
    int unsigned    cycles = 0;
    bit             calm;     // no idling on either side

    distinct_random_slot_sampler_top dut (.*);

    always begin
        i_clk = 1'b1; #10;
        i_clk = 1'b0; #10;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("distinct_random_slot_sampler_top verification failed");
            $finish;
        end
    end

    // receiver: sample at rising edge, change tready at falling edge
    always @(posedge i_clk)
        if (i_rst_n && o_m_tvalid && i_m_tready)
            board.check_beat(o_m_tdata, o_m_tuser, o_m_tlast);

    always @(negedge i_clk)
        i_m_tready <= calm ? 1'b1 : ($urandom_range(99) >= 27);

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [63:0] val);
        @(negedge i_clk);
        i_cfg_we   = 1'b1;
        i_cfg_idx  = idx;
        i_cfg_data = val;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
        board.set_reg(idx, val);
    endtask

    task automatic send_batch(logic [15:0] rnd, logic [7:0] file, logic [5:0] cnt,
                              logic [10:0] slots);
        while (!calm && $urandom_range(99) < 27) @(negedge i_clk);
        i_s_tvalid = 1'b1;
        i_s_tdata  = {7'd0, slots, cnt, file, rnd};
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
        board.note_batch(rnd, file, cnt, slots);
        @(negedge i_clk);
        i_s_tvalid = 1'b0;
    endtask

    task automatic drain();
        while (board.pending.size() != 0) @(negedge i_clk);
        repeat (600) @(negedge i_clk);
    endtask

    task automatic random_batch();
        logic [5:0]  cnt;
        logic [10:0] slots;
        int unsigned p;
        p = $urandom_range(99);
        if (p < 70) begin
            slots = 11'($urandom_range(1024, 1));
            cnt   = 6'($urandom_range(8, 1));
            if (slots < 64 && cnt > slots) cnt = 6'(slots);
        end else if (p < 85) begin
            slots = 11'($urandom_range(2047, 0));
            cnt   = 6'($urandom_range(63, 0));
        end else begin
            slots = 11'($urandom_range(40, 1));
            cnt   = 6'($urandom_range(32, 1));
        end
        send_batch(16'($urandom), 8'($urandom), cnt, slots);
    endtask

    initial begin
        board      = new();
        calm       = 1'b0;
        i_rst_n    = 1'b0;
        i_cfg_we   = 1'b0;
        i_cfg_idx  = REG_SEED;
        i_cfg_data = '0;
        i_s_tvalid = 1'b0;
        i_s_tdata  = '0;
        i_m_tready = 1'b0;
        repeat (4) @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed: field extremes and the special cases
        send_batch(16'd0, 8'd0, 6'd1, 11'd1);
        send_batch(16'hffff, 8'hff, 6'd32, 11'd1024);
        send_batch(16'd5, 8'd3, 6'd0, 11'd100);      // no draw, no beat
        send_batch(16'd6, 8'd3, 6'd63, 11'd1024);    // count saturates
        send_batch(16'd7, 8'd4, 6'd4, 11'd0);        // zero slots fails
        send_batch(16'd8, 8'd5, 6'd10, 11'd2047);    // slots saturate
        send_batch(16'd9, 8'd6, 6'd5, 11'd3);        // more than slots: fails
        send_batch(16'd10, 8'd7, 6'd3, 11'd3);
        send_batch(16'd10, 8'd7, 6'd3, 11'd3);       // repeat: nothing novel
        send_batch(16'haaaa, 8'h55, 6'd21, 11'h555);
        send_batch(16'h5555, 8'haa, 6'd42, 11'h2aa);
        drain();
        write_reg(REG_SEED, 64'hffff_ffff_ffff_ffff);
        write_reg(REG_STRIDE, 64'hffff_ffff_ffff_ffff);   // max stride, widest offsets
        send_batch(16'd1, 8'd1, 6'd32, 11'd1024);
        send_batch(16'd2, 8'd1, 6'd8, 11'd64);
        drain();
        write_reg(REG_STRIDE, 64'd0);
        send_batch(16'd3, 8'd2, 6'd4, 11'd17);
        drain();
        write_reg(REG_STRIDE, 64'd12345);
        write_reg(REG_SEED, 64'h0123_4567_89ab_cdef);

        for (int i = 0; i < 450; i++) begin
            if (i == 150) begin
                drain();
                write_reg(REG_SEED, {$urandom, $urandom});
                write_reg(REG_STRIDE, 64'(16384) * $urandom_range(1024, 1));
            end
            if (i == 250) begin
                drain();
                write_reg(REG_STRIDE, 64'd1 << 40);
                calm = 1'b1;
            end
            if (i == 330) calm = 1'b0;
            random_batch();
        end
        drain();
        if (board.errors == 0 && board.pending.size() == 0)
            $display("distinct_random_slot_sampler_top verification clean");
        else
            $display("distinct_random_slot_sampler_top verification failed");
        $finish;
    end
endmodule
